// ===== design/tsrg_pkg.sv =====
// ----------------------------------------------------------------------------
// tsrg_pkg: shared types and constants of the two-seed random generator
// Widths, modulus and seeding constants, and the operand bundle of the
// shared three-input adder.
// ----------------------------------------------------------------------------
package tsrg_pkg;

  localparam int unsigned SEED_W  = 64;
  localparam int unsigned VALUE_W = 31;
  localparam int unsigned FRAC_W  = 33;
  localparam int unsigned CHUNK_W = 30;

  // Call kinds carried on in_kind
  localparam logic KIND_SEED_ARG = 1'b0;
  localparam logic KIND_SESSION  = 1'b1;

  // Modulus 2^30-1; folding works because 2^30 = 1 (mod 2^30-1).
  localparam logic [CHUNK_W-1:0] MOD_VALUE = 30'h3FFF_FFFF;

  // Seeding: s1 = v*0x10001 + 55555555, s2 = v*0x10000001 (shift-add form).
  localparam int unsigned         SEED1_SHIFT = 16;
  localparam int unsigned         SEED2_SHIFT = 28;
  localparam logic [SEED_W-1:0]   SEED1_ADD   = 64'd55555555;

  localparam logic [SEED_W-1:0]   STEP_BUMP   = 64'd23;
  localparam logic [SEED_W-1:0]   STEP_ADD    = 64'd33;

  typedef struct packed {
    logic [SEED_W-1:0] a;
    logic [SEED_W-1:0] b;
    logic [SEED_W-1:0] c;
  } add3_opnd_t;

endpackage

// ===== design/tsrg_add3.sv =====
// ----------------------------------------------------------------------------
// tsrg_add3: shared 64-bit three-operand adder
// Carry-save stage followed by one carry-propagate add, wrapping in 64 bits.
// ----------------------------------------------------------------------------
module tsrg_add3 (
  input  tsrg_pkg::add3_opnd_t             opnd,
  output logic [tsrg_pkg::SEED_W-1:0]      sum
);
  import tsrg_pkg::*;

  logic [SEED_W-1:0] xor_part;
  logic [SEED_W-1:0] carry_part;

  // 3:2 compression
  assign xor_part   = opnd.a ^ opnd.b ^ opnd.c;
  assign carry_part = ((opnd.a & opnd.b) | (opnd.a & opnd.c) | (opnd.b & opnd.c)) << 1;

  assign sum = xor_part + carry_part;

endmodule

// ===== design/tsrg_frac.sv =====
// ----------------------------------------------------------------------------
// tsrg_frac: Q32 fraction of a draw
// floor(v * 2^32 / (2^30-1)) = 4v + floor(4v / (2^30-1)), the second term
// found by one fold and one compare.
// ----------------------------------------------------------------------------
module tsrg_frac (
  input  logic [tsrg_pkg::VALUE_W-1:0] value,
  output logic [tsrg_pkg::FRAC_W-1:0]  fraction
);
  import tsrg_pkg::*;

  logic [FRAC_W-1:0]  v4;
  logic [2:0]         hi;
  logic [CHUNK_W:0]   folded;
  logic               wrap;

  assign v4     = {value, 2'b00};
  assign hi     = v4[FRAC_W-1:CHUNK_W];
  assign folded = {1'b0, v4[CHUNK_W-1:0]} + {{(CHUNK_W-2){1'b0}}, hi};
  // folded < 2 * modulus, so the quotient bit is a single compare
  assign wrap   = (folded >= {1'b0, MOD_VALUE});

  assign fraction = v4 + {{(FRAC_W-3){1'b0}}, hi} + {{(FRAC_W-1){1'b0}}, wrap};

endmodule

// ===== design/two_seed_rand_generator_core.sv =====
// ----------------------------------------------------------------------------
// two_seed_rand_generator_core: two-seed pseudo-random draw generator
// One input transaction is one call and yields one result transaction.
// ----------------------------------------------------------------------------
// Each transaction runs through a small sequencer around one shared 64-bit
// three-operand adder. With the stored seeds (kind 1, or kind 0 with a
// constant seed once seeded) the block stays busy until the second seed
// has been reduced, and takes the next transaction only once it is back
// in idle; rebuilding the seeds from the seed argument costs two more
// adder passes ahead of the mix. The result is offered after the bump
// step from an output register; if an earlier result is still held
// there, the sequencer waits before loading it. The adder is the pacing
// resource: one pass each for the mix 3*s1+s2, the two modulo folds,
// the final correction, the +23 bump and the s2 sum, with the folds and
// correction repeated for seed two.
// ----------------------------------------------------------------------------
module two_seed_rand_generator_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_kind,
  input  logic signed [tsrg_pkg::SEED_W-1:0] in_seed_value,
  input  logic                              in_seed_is_constant,
  input  logic [tsrg_pkg::SEED_W-1:0]       in_session_seed_one,
  input  logic [tsrg_pkg::SEED_W-1:0]       in_session_seed_two,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tsrg_pkg::VALUE_W-1:0]      out_random_value,
  output logic [tsrg_pkg::FRAC_W-1:0]       out_fraction_q32
);
  import tsrg_pkg::*;

  // Sequencer states
  localparam logic [3:0] ST_IDLE   = 4'd0;  // wait for a transaction
  localparam logic [3:0] ST_SEED1  = 4'd1;  // s1 = v + (v << 16) + 55555555
  localparam logic [3:0] ST_SEED2  = 4'd2;  // s2 = v + (v << 28)
  localparam logic [3:0] ST_MIX    = 4'd3;  // t = s1 + 2*s1 + s2
  localparam logic [3:0] ST_FOLD_A = 4'd4;  // fold 64 bits to 32
  localparam logic [3:0] ST_FOLD_B = 4'd5;  // fold 32 bits to 31
  localparam logic [3:0] ST_CORR   = 4'd6;  // subtract modulus if needed
  localparam logic [3:0] ST_BUMP   = 4'd7;  // add 23 if new s1 equals old s1
  localparam logic [3:0] ST_LOAD   = 4'd8;  // move draw into output register
  localparam logic [3:0] ST_SUM2   = 4'd9;  // t = s1 + s2 + 33

  logic [3:0]          state_r, state_nxt;
  logic                phase_r, phase_nxt;     // 0: reducing seed one, 1: seed two
  logic                seeded_r, seeded_nxt;
  logic [SEED_W-1:0]   s1_r, s1_nxt;
  logic [SEED_W-1:0]   s2_r, s2_nxt;
  logic [SEED_W-1:0]   t_r, t_nxt;
  logic [SEED_W-1:0]   sv_r, sv_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]  out_value_r, out_value_nxt;
  logic [FRAC_W-1:0]   out_frac_r, out_frac_nxt;

  add3_opnd_t          opnd;
  logic [SEED_W-1:0]   sum;
  logic [SEED_W-1:0]   corr_sum;
  logic [FRAC_W-1:0]   frac;
  logic                accept;
  logic                out_free;

  tsrg_add3 u_add3 (
    .opnd (opnd),
    .sum  (sum)
  );

  tsrg_frac u_frac (
    .value    (s1_r[VALUE_W-1:0]),
    .fraction (frac)
  );

  assign in_ready         = (state_r == ST_IDLE);
  assign accept           = in_valid && in_ready;
  assign out_valid        = out_valid_r;
  assign out_random_value = out_value_r;
  assign out_fraction_q32 = out_frac_r;
  assign out_free         = !out_valid_r || out_ready;
  assign corr_sum         = sum;

  // Operand selection for the shared adder
  always_comb begin
    opnd = '{a: '0, b: '0, c: '0};
    unique case (state_r)
      ST_SEED1: begin
        opnd = '{a: sv_r, b: sv_r << SEED1_SHIFT, c: SEED1_ADD};
      end
      ST_SEED2: begin
        opnd = '{a: sv_r, b: sv_r << SEED2_SHIFT, c: '0};
      end
      ST_MIX: begin
        opnd = '{a: s1_r, b: s1_r << 1, c: s2_r};
      end
      ST_FOLD_A: begin
        opnd = '{a: {{(SEED_W-CHUNK_W){1'b0}}, t_r[CHUNK_W-1:0]},
                 b: {{(SEED_W-CHUNK_W){1'b0}}, t_r[2*CHUNK_W-1:CHUNK_W]},
                 c: {{(2*CHUNK_W){1'b0}}, t_r[SEED_W-1:2*CHUNK_W]}};
      end
      ST_FOLD_B: begin
        opnd = '{a: {{(SEED_W-CHUNK_W){1'b0}}, t_r[CHUNK_W-1:0]},
                 b: {{(SEED_W-2){1'b0}}, t_r[CHUNK_W+1:CHUNK_W]},
                 c: '0};
      end
      ST_CORR: begin
        // add the two's complement of the modulus
        opnd = '{a: t_r, b: ~{{(SEED_W-CHUNK_W){1'b0}}, MOD_VALUE}, c: 64'd1};
      end
      ST_BUMP: begin
        opnd = '{a: t_r, b: (t_r == s1_r) ? STEP_BUMP : '0, c: '0};
      end
      ST_SUM2: begin
        opnd = '{a: s1_r, b: s2_r, c: STEP_ADD};
      end
      ST_IDLE, ST_LOAD: begin
        opnd = '{a: '0, b: '0, c: '0};
      end
      default: begin
        opnd = '{a: '0, b: '0, c: '0};
      end
    endcase
  end

  // Sequencer and datapath next state
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    seeded_nxt    = seeded_r;
    s1_nxt        = s1_r;
    s2_nxt        = s2_r;
    t_nxt         = t_r;
    sv_nxt        = sv_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    out_frac_nxt  = out_frac_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          phase_nxt = 1'b0;
          sv_nxt    = in_seed_value;
          state_nxt = ST_MIX;
          if (in_kind == KIND_SEED_ARG) begin
            // reseed unless the seed is constant and the seeds are already set
            if (!seeded_r || !in_seed_is_constant) begin
              seeded_nxt = 1'b1;
              state_nxt  = ST_SEED1;
            end
          end else if (s1_r == '0) begin
            s1_nxt     = in_session_seed_one;
            s2_nxt     = in_session_seed_two;
            seeded_nxt = 1'b1;
          end
        end
      end
      ST_SEED1: begin
        s1_nxt    = sum;
        state_nxt = ST_SEED2;
      end
      ST_SEED2: begin
        s2_nxt    = sum;
        state_nxt = ST_MIX;
      end
      ST_MIX: begin
        t_nxt     = sum;
        state_nxt = ST_FOLD_A;
      end
      ST_FOLD_A: begin
        t_nxt     = sum;
        state_nxt = ST_FOLD_B;
      end
      ST_FOLD_B: begin
        t_nxt     = sum;
        state_nxt = ST_CORR;
      end
      ST_CORR: begin
        // a negative difference means the value was already below the modulus
        if (!corr_sum[SEED_W-1]) begin
          t_nxt = corr_sum;
        end
        if (phase_r) begin
          s2_nxt    = corr_sum[SEED_W-1] ? t_r : corr_sum;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_BUMP;
        end
      end
      ST_BUMP: begin
        s1_nxt    = sum;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = s1_r[VALUE_W-1:0];
          out_frac_nxt  = frac;
          state_nxt     = ST_SUM2;
        end
      end
      ST_SUM2: begin
        t_nxt     = sum;
        phase_nxt = 1'b1;
        state_nxt = ST_FOLD_A;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= 1'b0;
      seeded_r    <= 1'b0;
      s1_r        <= '0;
      s2_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      seeded_r    <= seeded_nxt;
      s1_r        <= s1_nxt;
      s2_r        <= s2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r         <= t_nxt;
    sv_r        <= sv_nxt;
    out_value_r <= out_value_nxt;
    out_frac_r  <= out_frac_nxt;
  end

endmodule

// ===== design/tsrg_checker.sv =====
// ----------------------------------------------------------------------------
// tsrg_checker: port-level checks of the two-seed random generator
// Watches handshakes and result fields; bound to the top level.
// ----------------------------------------------------------------------------
module tsrg_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [tsrg_pkg::VALUE_W-1:0]      out_random_value,
  input logic [tsrg_pkg::FRAC_W-1:0]       out_fraction_q32
);
  import tsrg_pkg::*;

  logic [1:0] pend_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // count transactions taken in but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (in_acc && !out_acc) begin
      pend_r <= pend_r + 2'd1;
    end else if (out_acc && !in_acc) begin
      pend_r <= pend_r - 2'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_random_value)
      && $stable(out_fraction_q32))
    else $error("result dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("new transaction taken right after acceptance");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> (pend_r != 2'd0) || in_acc)
    else $error("result delivered without an outstanding transaction");

  a_frac_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_fraction_q32 >= {out_random_value, 2'b00})
      && (out_fraction_q32 <= {out_random_value, 2'b00} + 33'd4))
    else $error("fraction inconsistent with drawn value");

endmodule

bind two_seed_rand_generator_core tsrg_checker u_tsrg_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_random_value (out_random_value),
  .out_fraction_q32 (out_fraction_q32)
);
